[design/polar_grid_node_coordinates_defines.svh]
// Assertion macros for the polar grid node coordinate block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef POLAR_GRID_NODE_COORDINATES_DEFINES_SVH
`define POLAR_GRID_NODE_COORDINATES_DEFINES_SVH

// checked outside reset
`define PGN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PGN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pgn_pkg.sv]
// Shared constants, types and helpers for the polar grid node block.
// No dependencies; imported by every RTL module.
`timescale 1ns / 1ps
`default_nettype none
package pgn_pkg;

  localparam int INDEX_BITS    = 12;
  localparam int CORDIC_STAGES = 24;

  localparam int Q_W      = 32;                    // Q16.16 and binary angle width
  localparam int CW       = 34;                    // CORDIC x/y width, Q2.30 plus headroom
  localparam int ZW       = 34;                    // CORDIC residual angle width
  localparam int CFRAC    = 30;                    // fraction bits of sin/cos
  localparam int PW       = Q_W + CW;              // radius times sin/cos
  localparam int PRODR_W  = INDEX_BITS + 1 + Q_W;  // index times radial step
  localparam int ATAN_IW  = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [Q_W-1:0] INV_GAIN_Q30 = 32'h26DD3B6A;

  localparam logic signed [PW-1:0] Q_MAX_W = {{(PW-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [PW-1:0] Q_MIN_W = {{(PW-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
  localparam logic signed [PW-1:0] ROUND_W = $signed(PW'(1) << (CFRAC-1));

  localparam logic [Q_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER_RADIUS = 3'd0,
    REG_RADIAL_STEP  = 3'd1,
    REG_ANGLE_STEP   = 3'd2,
    REG_ORIGIN_X     = 3'd3,
    REG_ORIGIN_Y     = 3'd4,
    REG_ORIGIN_Z     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                  vld;
    logic                  flip;
    logic                  sat;
    logic signed [Q_W-1:0] r;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } cordic_t;

  // {clipped, value} of a wide signed value limited to Q16.16
  function automatic logic [Q_W:0] clip_q(input logic signed [PW-1:0] v);
    logic [Q_W:0] res;
    if (v > Q_MAX_W) begin
      res = {1'b1, Q_MAX_W[Q_W-1:0]};
    end else if (v < Q_MIN_W) begin
      res = {1'b1, Q_MIN_W[Q_W-1:0]};
    end else begin
      res = {1'b0, v[Q_W-1:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[design/pgn_front.sv]
// Front end: radius and angle products, radius clip, quadrant fold.
// Two register stages; depends on pgn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgn_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_vld,
  input  wire [pgn_pkg::INDEX_BITS-1:0] radial_index,
  input  wire [pgn_pkg::INDEX_BITS-1:0] angular_index,
  input  wire signed [pgn_pkg::Q_W-1:0] inner_radius,
  input  wire signed [pgn_pkg::Q_W-1:0] radial_step,
  input  wire [pgn_pkg::Q_W-1:0]        angle_step,
  output pgn_pkg::cordic_t              d_out
);
  import pgn_pkg::*;

  logic                      a_vld_r;
  logic signed [PRODR_W-1:0] prod_r, prod_nxt;
  logic [Q_W-1:0]            ang_r, ang_nxt;
  logic [INDEX_BITS+Q_W-1:0] ang_wide;

  cordic_t                   b_r, b_nxt;
  logic signed [PRODR_W:0]   rsum;
  logic [Q_W:0]              rclip;
  logic                      flip;
  logic [Q_W-1:0]            zang;

  always_comb begin
    prod_nxt = $signed({1'b0, radial_index}) * radial_step;
    ang_wide = angular_index * angle_step;
    ang_nxt  = ang_wide[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
    if (en) begin
      prod_r <= prod_nxt;
      ang_r  <= ang_nxt;
    end
  end

  always_comb begin
    rsum  = $signed({{(PRODR_W+1-Q_W){inner_radius[Q_W-1]}}, inner_radius})
          + $signed({prod_r[PRODR_W-1], prod_r});
    rclip = clip_q(PW'(rsum));
    flip  = ang_r[Q_W-1] ^ ang_r[Q_W-2];
    zang  = {ang_r[Q_W-1] ^ flip, ang_r[Q_W-2:0]};
    b_nxt.vld  = a_vld_r;
    b_nxt.flip = flip;
    b_nxt.sat  = rclip[Q_W];
    b_nxt.r    = $signed(rclip[Q_W-1:0]);
    b_nxt.x    = $signed({{(CW-Q_W){1'b0}}, INV_GAIN_Q30});
    b_nxt.y    = '0;
    b_nxt.z    = $signed({{(ZW-Q_W){zang[Q_W-1]}}, zang});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
    end else if (en) begin
      b_r.vld <= b_nxt.vld;
    end
    if (en) begin
      b_r.flip <= b_nxt.flip;
      b_r.sat  <= b_nxt.sat;
      b_r.r    <= b_nxt.r;
      b_r.x    <= b_nxt.x;
      b_r.y    <= b_nxt.y;
      b_r.z    <= b_nxt.z;
    end
  end

  assign d_out = b_r;

endmodule
`default_nettype wire

[design/pgn_cordic_stage.sv]
// One rotation-mode CORDIC iteration with its output register.
// Depends on pgn_pkg (types, arctangent table).
`timescale 1ns / 1ps
`default_nettype none
module pgn_cordic_stage (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         en,
  input  wire [pgn_pkg::ATAN_IW-1:0]  stage_idx,
  input  wire pgn_pkg::cordic_t       d_in,
  output pgn_pkg::cordic_t            d_out
);
  import pgn_pkg::*;

  cordic_t              s_r, s_nxt;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  always_comb begin
    dx    = d_in.y >>> stage_idx;
    dy    = d_in.x >>> stage_idx;
    at    = $signed({{(ZW-Q_W){1'b0}}, ATAN_TAB[stage_idx]});
    s_nxt = d_in;
    if (!d_in.z[ZW-1]) begin
      s_nxt.x = d_in.x - dx;
      s_nxt.y = d_in.y + dy;
      s_nxt.z = d_in.z - at;
    end else begin
      s_nxt.x = d_in.x + dx;
      s_nxt.y = d_in.y - dy;
      s_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r.vld <= s_nxt.vld;
    end
    if (en) begin
      s_r.flip <= s_nxt.flip;
      s_r.sat  <= s_nxt.sat;
      s_r.r    <= s_nxt.r;
      s_r.x    <= s_nxt.x;
      s_r.y    <= s_nxt.y;
      s_r.z    <= s_nxt.z;
    end
  end

  assign d_out = s_r;

endmodule
`default_nettype wire

[design/pgn_back.sv]
// Back end: unfold, radius multiply, round, origin add, clip, output register.
// Two register stages; depends on pgn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgn_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire pgn_pkg::cordic_t        d_in,
  input  wire signed [pgn_pkg::Q_W-1:0] origin_x,
  input  wire signed [pgn_pkg::Q_W-1:0] origin_y,
  input  wire signed [pgn_pkg::Q_W-1:0] origin_z,
  output logic                         out_vld,
  output logic signed [pgn_pkg::Q_W-1:0] pos_x,
  output logic signed [pgn_pkg::Q_W-1:0] pos_y,
  output logic signed [pgn_pkg::Q_W-1:0] pos_z,
  output logic                         saturated
);
  import pgn_pkg::*;

  logic                 m_vld_r, m_sat_r;
  logic signed [PW-1:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [CW-1:0] cx, sy;

  logic signed [PW-1:0] vx, vy;
  logic [Q_W:0]         cx_clip, cy_clip;

  logic                 vld_r, sat_r;
  logic [Q_W-1:0]       x_r, y_r, z_r;

  always_comb begin
    cx     = d_in.flip ? -d_in.x : d_in.x;
    sy     = d_in.flip ? -d_in.y : d_in.y;
    px_nxt = d_in.r * cx;
    py_nxt = d_in.r * sy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= d_in.vld;
    end
    if (en) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      m_sat_r <= d_in.sat;
    end
  end

  always_comb begin
    vx      = ((px_r + ROUND_W) >>> CFRAC) + PW'(origin_x);
    vy      = ((py_r + ROUND_W) >>> CFRAC) + PW'(origin_y);
    cx_clip = clip_q(vx);
    cy_clip = clip_q(vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= m_vld_r;
    end
    if (en) begin
      x_r   <= cx_clip[Q_W-1:0];
      y_r   <= cy_clip[Q_W-1:0];
      z_r   <= origin_z;
      sat_r <= m_sat_r | cx_clip[Q_W] | cy_clip[Q_W];
    end
  end

  assign out_vld   = vld_r;
  assign pos_x     = $signed(x_r);
  assign pos_y     = $signed(y_r);
  assign pos_z     = $signed(z_r);
  assign saturated = sat_r;

endmodule
`default_nettype wire

[design/polar_grid_node_coordinates.sv]
// Polar grid node coordinates: one node position per beat, fully pipelined.
// A new index pair is taken every cycle the output is free or being taken;
// the pipe holds two front stages for the radius and
// angle products, one stage per CORDIC iteration, and two back stages for the
// radius multiply and the round/offset/clip. The whole pipe advances on one
// enable, so a stall at the output holds every stage in place.
// Depends on pgn_pkg, pgn_front, pgn_cordic_stage and pgn_back.
`timescale 1ns / 1ps
`default_nettype none
module polar_grid_node_coordinates (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [pgn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [pgn_pkg::Q_W-1:0]           cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [pgn_pkg::INDEX_BITS-1:0]    in_radial_index,
  input  wire [pgn_pkg::INDEX_BITS-1:0]    in_angular_index,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [pgn_pkg::Q_W-1:0]   out_pos_x,
  output logic signed [pgn_pkg::Q_W-1:0]   out_pos_y,
  output logic signed [pgn_pkg::Q_W-1:0]   out_pos_z,
  output logic                             out_saturated
);
  import pgn_pkg::*;

  logic [Q_W-1:0] inner_radius_r, radial_step_r, angle_step_r;
  logic [Q_W-1:0] origin_x_r, origin_y_r, origin_z_r;
  logic           en;
  cordic_t        stg [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_radius_r <= '0;
      radial_step_r  <= '0;
      angle_step_r   <= '0;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      origin_z_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INNER_RADIUS: inner_radius_r <= cfg_wdata;
        REG_RADIAL_STEP:  radial_step_r  <= cfg_wdata;
        REG_ANGLE_STEP:   angle_step_r   <= cfg_wdata;
        REG_ORIGIN_X:     origin_x_r     <= cfg_wdata;
        REG_ORIGIN_Y:     origin_y_r     <= cfg_wdata;
        REG_ORIGIN_Z:     origin_z_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  pgn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_vld        (in_valid),
    .radial_index  (in_radial_index),
    .angular_index (in_angular_index),
    .inner_radius  ($signed(inner_radius_r)),
    .radial_step   ($signed(radial_step_r)),
    .angle_step    (angle_step_r),
    .d_out         (stg[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    pgn_cordic_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_idx (ATAN_IW'(i)),
      .d_in      (stg[i]),
      .d_out     (stg[i+1])
    );
  end

  pgn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .d_in      (stg[CORDIC_STAGES]),
    .origin_x  ($signed(origin_x_r)),
    .origin_y  ($signed(origin_y_r)),
    .origin_z  ($signed(origin_z_r)),
    .out_vld   (out_valid),
    .pos_x     (out_pos_x),
    .pos_y     (out_pos_y),
    .pos_z     (out_pos_z),
    .saturated (out_saturated)
  );

endmodule
`default_nettype wire

[design/pgn_checker.sv]
// Port-level checker for polar_grid_node_coordinates, bound to the top level.
// Depends on pgn_pkg and polar_grid_node_coordinates_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "polar_grid_node_coordinates_defines.svh"
module pgn_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire signed [pgn_pkg::Q_W-1:0]    out_pos_x,
  input wire signed [pgn_pkg::Q_W-1:0]    out_pos_y,
  input wire signed [pgn_pkg::Q_W-1:0]    out_pos_z,
  input wire                              out_saturated
);
  // pipe moves whenever the output register is free or drained
  `PGN_ASSERT(a_ready_follows_out, in_ready == (!out_valid || out_ready), "in_ready mismatch")

  // reset empties the pipe
  `PGN_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled beat holds its payload
  `PGN_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pos_z) && $stable(out_saturated), "stalled result changed")

  // a stall blocks the input side in the same cycle
  `PGN_ASSERT(a_stall_blocks_in, out_valid && !out_ready |-> !in_ready, "input taken during stall")
endmodule

bind polar_grid_node_coordinates pgn_checker u_pgn_checker (.*);
`default_nettype wire
